// File: hw/rtl/mctt_pkg.sv
// Shared types and constants for the multi-channel tick timer bank.
// No dependencies; imported by the controller, the datapath and the top level.
package mctt_pkg;

    localparam int CMD_W      = 2;
    localparam int ID_W       = 8;
    localparam int PERIOD_W   = 32;
    localparam int MASK_W     = 8;
    localparam int RUN_W      = 31;
    localparam int DIV10_W    = 4;
    localparam int DIV50_W    = 6;
    localparam int S_TDATA_W  = 40;
    localparam int M_TDATA_W  = 48;
    localparam int M_PAD_W    = M_TDATA_W - (MASK_W + RUN_W + 3);

    // Command codes carried on s_tuser
    localparam logic [CMD_W-1:0] CMD_TICK = 2'd0;
    localparam logic [CMD_W-1:0] CMD_ONCE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_AUTO = 2'd2;
    localparam logic [CMD_W-1:0] CMD_STOP = 2'd3;

    // Run-time counter skips 0x7FFFFFFF and wraps to zero
    localparam logic [RUN_W-1:0]   RUN_LAST   = 31'h7FFF_FFFE;
    localparam logic [DIV10_W-1:0] DIV10_LAST = 4'd9;
    localparam logic [DIV50_W-1:0] DIV50_LAST = 6'd49;

    typedef struct packed {
        logic accept;    // input transaction taken this cycle
        logic sweep_en;  // update the timer under the sweep index
        logic load_out;  // copy the finished result into the output register
    } mctt_cmd_t;

    typedef struct packed {
        logic sweep_last; // sweep index points at the last timer
    } mctt_status_t;

endpackage

// File: hw/rtl/multi_channel_tick_timer_bank_top.sv
// Top level of the multi-channel tick timer bank.
// Depends on mctt_pkg, mctt_ctrl and mctt_datapath.
//
// A bank of NUM_TIMERS one-shot or auto-reload tick timers with one result
// transaction per command transaction. The command travels on s_tuser: tick,
// start one-shot, start auto-reload or stop. Start and stop take the timer
// index and period from s_tdata; a tick ignores both. A start or stop goes
// from acceptance straight to the done state, which loads the result into
// the output register once that is free and then takes the next command. A
// tick first sweeps the timers one per cycle through a single
// decrement-and-compare unit, then reaches the done state in the same way.
// Only one command is in flight at a time; the result sits in an output
// register, so a waiting result does not hold off the next command until the
// new result is ready to be written. An id beyond the bank sets bad_id and
// changes nothing. fired_mask covers timers 0 to 7 only. run_time counts ticks
// and wraps to zero at 0x7FFFFFFF; pulse_10 and pulse_50 mark every tenth and
// fiftieth tick.
module multi_channel_tick_timer_bank_top #(
    parameter int NUM_TIMERS = 8
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // Command channel
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [mctt_pkg::S_TDATA_W-1:0]      s_tdata,  // timer_id[7:0], period[39:8]
    input  logic [mctt_pkg::CMD_W-1:0]          s_tuser,  // command[1:0]
    // Result channel
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [mctt_pkg::M_TDATA_W-1:0]      m_tdata   // fired_mask[7:0], run_time[38:8],
                                                          // pulse_10[39], pulse_50[40],
                                                          // bad_id[41], zero[47:42]
);
    import mctt_pkg::*;

    mctt_cmd_t    ctrl;
    mctt_status_t status;

    // Sequence the sweep and the output hand-off
    mctt_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_command (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .status    (status),
        .ctrl      (ctrl)
    );

    // Hold the timer state and build each result
    mctt_datapath #(
        .NUM_TIMERS (NUM_TIMERS)
    ) u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctrl     (ctrl),
        .status   (status),
        .command  (s_tuser),
        .timer_id (s_tdata[ID_W-1:0]),
        .period   (s_tdata[ID_W +: PERIOD_W]),
        .out_data (m_tdata)
    );

    // An accepted command leaves the controller busy on the next cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("command accepted while previous one still in progress");

    // Never overwrite a result that has not been taken
    assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.load_out |-> (!m_tvalid || m_tready))
        else $error("result register overwritten before transfer");

    // A rejected id comes only from a start or stop, never with tick pulses
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tdata[MASK_W + RUN_W + 2] &&
                       (m_tdata[MASK_W + RUN_W] || m_tdata[MASK_W + RUN_W + 1] ||
                        (m_tdata[MASK_W-1:0] != '0))))
        else $error("bad id reported together with tick results");

endmodule

// File: hw/rtl/mctt_ctrl.sv
// Controller state machine for the tick timer bank.
// Depends on mctt_pkg; drives the datapath through mctt_cmd_t.
module mctt_ctrl (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [mctt_pkg::CMD_W-1:0]  s_command,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    input  mctt_pkg::mctt_status_t      status,
    output mctt_pkg::mctt_cmd_t         ctrl
);
    import mctt_pkg::*;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SWEEP = 2'd1;
    localparam logic [1:0] ST_DONE  = 2'd2;

    logic [1:0] state_reg, state_next;
    logic       out_valid_reg, out_valid_next;
    logic       out_free;

    assign out_free = !out_valid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;

    always_comb begin
        state_next    = state_reg;
        ctrl.accept   = 1'b0;
        ctrl.sweep_en = 1'b0;
        ctrl.load_out = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    ctrl.accept = 1'b1;
                    state_next  = (s_command == CMD_TICK) ? ST_SWEEP : ST_DONE;
                end
            end
            ST_SWEEP: begin
                ctrl.sweep_en = 1'b1;
                if (status.sweep_last) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    ctrl.load_out = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (ctrl.load_out) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// File: hw/rtl/mctt_datapath.sv
// Datapath of the tick timer bank: timer state, sweep unit, run-time counters
// and the output register. Depends on mctt_pkg; steered by mctt_ctrl.
module mctt_datapath #(
    parameter int NUM_TIMERS = 8
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  mctt_pkg::mctt_cmd_t              ctrl,
    output mctt_pkg::mctt_status_t           status,
    input  logic [mctt_pkg::CMD_W-1:0]       command,
    input  logic [mctt_pkg::ID_W-1:0]        timer_id,
    input  logic [mctt_pkg::PERIOD_W-1:0]    period,
    output logic [mctt_pkg::M_TDATA_W-1:0]   out_data
);
    import mctt_pkg::*;

    localparam int IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(NUM_TIMERS - 1);
    localparam logic [ID_W-1:0]  ID_LIMIT = ID_W'(NUM_TIMERS);

    logic [PERIOD_W-1:0]   remaining_reg [NUM_TIMERS];
    logic [PERIOD_W-1:0]   reload_reg    [NUM_TIMERS];
    logic [NUM_TIMERS-1:0] auto_reg;
    logic [NUM_TIMERS-1:0] armed_reg;
    logic [IDX_W-1:0]      idx_reg;
    logic [MASK_W-1:0]     fired_reg;
    logic [RUN_W-1:0]      elapsed_reg;
    logic [DIV10_W-1:0]    div10_reg;
    logic [DIV50_W-1:0]    div50_reg;
    logic                  p10_reg;
    logic                  p50_reg;
    logic                  bad_reg;
    logic [M_TDATA_W-1:0]  out_reg;

    logic [PERIOD_W-1:0]   cur_rem;
    logic [PERIOD_W-1:0]   rem_new;
    logic                  cur_auto;
    logic                  hit;
    logic                  fire;
    logic [MASK_W-1:0]     fire_bits;
    logic                  id_bad;
    logic [IDX_W-1:0]      wr_idx;

    assign status.sweep_last = (idx_reg == IDX_LAST);
    assign id_bad            = (timer_id >= ID_LIMIT);
    assign wr_idx            = timer_id[IDX_W-1:0];
    assign out_data          = out_reg;

    // One timer per cycle: decrement a nonzero count, reload an auto timer on expiry, flag an armed expiry
    always_comb begin
        cur_rem  = remaining_reg[idx_reg];
        cur_auto = auto_reg[idx_reg];
        hit      = (cur_rem == PERIOD_W'(1));
        fire     = hit && armed_reg[idx_reg];
        if (cur_rem == '0) begin
            rem_new = cur_rem;
        end else if (hit) begin
            rem_new = cur_auto ? reload_reg[idx_reg] : '0;
        end else begin
            rem_new = cur_rem - PERIOD_W'(1);
        end
        for (int b = 0; b < MASK_W; b++) begin
            fire_bits[b] = fire && (32'(idx_reg) == b);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < NUM_TIMERS; k++) begin
                remaining_reg[k] <= '0;
                reload_reg[k]    <= '0;
            end
            auto_reg    <= '0;
            armed_reg   <= '0;
            idx_reg     <= '0;
            fired_reg   <= '0;
            elapsed_reg <= '0;
            div10_reg   <= '0;
            div50_reg   <= '0;
            p10_reg     <= 1'b0;
            p50_reg     <= 1'b0;
            bad_reg     <= 1'b0;
        end else begin
            if (ctrl.accept) begin
                fired_reg <= '0;
                idx_reg   <= '0;
                if (command == CMD_TICK) begin
                    bad_reg     <= 1'b0;
                    elapsed_reg <= (elapsed_reg == RUN_LAST) ? '0 :
                                   elapsed_reg + RUN_W'(1);
                    p10_reg     <= (div10_reg == DIV10_LAST);
                    div10_reg   <= (div10_reg == DIV10_LAST) ? '0 :
                                   div10_reg + DIV10_W'(1);
                    p50_reg     <= (div50_reg == DIV50_LAST);
                    div50_reg   <= (div50_reg == DIV50_LAST) ? '0 :
                                   div50_reg + DIV50_W'(1);
                end else begin
                    bad_reg <= id_bad;
                    p10_reg <= 1'b0;
                    p50_reg <= 1'b0;
                    if (!id_bad) begin
                        case (command)
                            CMD_ONCE, CMD_AUTO: begin
                                remaining_reg[wr_idx] <= period;
                                reload_reg[wr_idx]    <= period;
                                auto_reg[wr_idx]      <= (command == CMD_AUTO);
                                armed_reg[wr_idx]     <= 1'b1;
                            end
                            CMD_STOP: begin
                                armed_reg[wr_idx] <= 1'b0;
                            end
                            default: begin
                            end
                        endcase
                    end
                end
            end
            if (ctrl.sweep_en) begin
                remaining_reg[idx_reg] <= rem_new;
                if (fire && !cur_auto) begin
                    armed_reg[idx_reg] <= 1'b0;
                end
                fired_reg <= fired_reg | fire_bits;
                if (!status.sweep_last) begin
                    idx_reg <= idx_reg + IDX_W'(1);
                end
            end
        end
    end

    // Result register: fields from the highest bit down
    always_ff @(posedge aclk) begin
        if (ctrl.load_out) begin
            out_reg <= {M_PAD_W'(0), bad_reg, p50_reg, p10_reg, elapsed_reg, fired_reg};
        end
    end

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for multi_channel_tick_timer_bank_top.
// Needs mctt_pkg and the timer bank RTL. Runs directed then random commands
// through a queue-fed driver; a monitor checks every result against a predictor.
module tb_top;
    import mctt_pkg::*;

    localparam int N_TIMERS        = 8;
    localparam int SLOT_W          = $clog2(N_TIMERS);
    localparam int RANDOM_COMMANDS = 1800;
    localparam int CYCLE_LIMIT     = 400000;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int MAX_PRINTED     = 40;

    // One command transaction as offered on the slave side
    typedef struct {
        logic [CMD_W-1:0]    cmd;
        logic [ID_W-1:0]     id;
        logic [PERIOD_W-1:0] period;
    } timer_cmd_t;

    // One result transaction, field by field
    typedef struct {
        logic [MASK_W-1:0] fired;
        logic [RUN_W-1:0]  run_time;
        logic              p10;
        logic              p50;
        logic              bad;
    } timer_report_t;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic [CMD_W-1:0]     s_tuser  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;

    // Commands waiting to be offered, and results still owed by the block
    timer_cmd_t    commands_to_send[$];
    timer_report_t timer_reports_due[$];
    timer_cmd_t    offer;
    timer_report_t head_report;
    logic          offer_taken = 1'b0;
    logic          hold_off    = 1'b0;

    int unsigned total_commands = 0;
    int unsigned commands_sent  = 0;
    int unsigned results_seen   = 0;
    int unsigned mismatch_count = 0;
    int unsigned cycle_count    = 0;

    // Predicted state of the timer bank
    logic [PERIOD_W-1:0] count_left [N_TIMERS] = '{default: '0};
    logic [PERIOD_W-1:0] reload_to  [N_TIMERS] = '{default: '0};
    logic                reloads    [N_TIMERS] = '{default: 1'b0};
    logic                live       [N_TIMERS] = '{default: 1'b0};
    logic [RUN_W-1:0]    ticks_seen   = '0;
    logic [DIV10_W-1:0]  tenth_div    = '0;
    logic [DIV50_W-1:0]  fiftieth_div = '0;

    multi_channel_tick_timer_bank_top #(
        .NUM_TIMERS(N_TIMERS)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),   // timer_id[7:0], period[39:8]
        .s_tuser  (s_tuser),   // command[1:0]
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)    // fired_mask[7:0], run_time[38:8], pulse_10[39],
                               // pulse_50[40], bad_id[41], zero[47:42]
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // Apply one command to the predicted bank and return the result it causes.
    function automatic timer_report_t advance_bank(timer_cmd_t c);
        timer_report_t     r;
        logic [SLOT_W-1:0] slot;
        slot    = c.id[SLOT_W-1:0];
        r.fired = '0;
        r.p10   = 1'b0;
        r.p50   = 1'b0;
        r.bad   = 1'b0;
        if (c.cmd == CMD_TICK) begin
            // Decrement every running count; a count reaching zero fires if armed
            for (int k = 0; k < N_TIMERS; k++) begin
                if (count_left[k] != '0) begin
                    count_left[k] = count_left[k] - PERIOD_W'(1);
                    if (count_left[k] == '0) begin
                        if (reloads[k])
                            count_left[k] = reload_to[k];
                        if (live[k]) begin
                            if (k < MASK_W)
                                r.fired[k] = 1'b1;
                            if (!reloads[k])
                                live[k] = 1'b0;
                        end
                    end
                end
            end
            // Run time skips the all-ones value and wraps to zero
            ticks_seen = (ticks_seen == RUN_LAST) ? '0 : ticks_seen + RUN_W'(1);
            if (tenth_div == DIV10_LAST) begin
                tenth_div = '0;
                r.p10     = 1'b1;
            end else begin
                tenth_div = tenth_div + DIV10_W'(1);
            end
            if (fiftieth_div == DIV50_LAST) begin
                fiftieth_div = '0;
                r.p50        = 1'b1;
            end else begin
                fiftieth_div = fiftieth_div + DIV50_W'(1);
            end
        end else if (int'(c.id) >= N_TIMERS) begin
            r.bad = 1'b1;
        end else if (c.cmd == CMD_STOP) begin
            // Disarm only; the count carries on silently
            live[slot] = 1'b0;
        end else begin
            count_left[slot] = c.period;
            reload_to[slot]  = c.period;
            reloads[slot]    = (c.cmd == CMD_AUTO);
            live[slot]       = 1'b1;
        end
        r.run_time = ticks_seen;
        return r;
    endfunction

    task automatic queue_command(logic [CMD_W-1:0] cmd, logic [ID_W-1:0] id,
                                 logic [PERIOD_W-1:0] period);
        timer_cmd_t c;
        c.cmd    = cmd;
        c.id     = id;
        c.period = period;
        commands_to_send.push_back(c);
    endtask

    task automatic report_mismatch(string what, longint unsigned got,
                                   longint unsigned want);
        if (mismatch_count < MAX_PRINTED)
            $display("[%0t] result %0d: %s is 0x%0h, predicted 0x%0h",
                     $time, results_seen, what, got, want);
        mismatch_count++;
    endtask

    // Idle rates per phase: sender light / receiver heavy, then swapped, then none
    function automatic int unsigned sender_idle_pct();
        if (commands_sent < total_commands / 3)
            return 8;
        else if (commands_sent < 2 * total_commands / 3)
            return 57;
        return 0;
    endfunction

    function automatic int unsigned receiver_idle_pct();
        if (results_seen < total_commands / 3)
            return 57;
        else if (results_seen < 2 * total_commands / 3)
            return 8;
        return 0;
    endfunction

    // Driver: change inputs at the falling edge only, and only once the
    // current offer has gone through (or nothing is being offered).
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || offer_taken) begin
            offer_taken = 1'b0;
            if (commands_to_send.size() != 0 &&
                $urandom_range(99) >= sender_idle_pct()) begin
                offer = commands_to_send.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= {offer.period, offer.id};
                s_tuser  <= offer.cmd;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Predict as soon as a command transaction is taken
    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready) begin
            timer_reports_due.push_back(advance_bank(offer));
            offer_taken = 1'b1;
            commands_sent++;
        end
    end

    // Receiver back-pressure: random stalls, or a solid hold-off when asked
    always @(negedge aclk) begin
        if (!aresetn || hold_off)
            m_tready <= 1'b0;
        else
            m_tready <= ($urandom_range(99) >= receiver_idle_pct());
    end

    // Monitor: compare each result transaction with the oldest prediction
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (timer_reports_due.size() == 0) begin
                report_mismatch("unexpected result", 64'(m_tdata), 64'(0));
            end else begin
                head_report = timer_reports_due.pop_front();
                if (m_tdata[7:0] !== head_report.fired)
                    report_mismatch("fired_mask", 64'(m_tdata[7:0]),
                                    64'(head_report.fired));
                if (m_tdata[38:8] !== head_report.run_time)
                    report_mismatch("run_time", 64'(m_tdata[38:8]),
                                    64'(head_report.run_time));
                if (m_tdata[39] !== head_report.p10)
                    report_mismatch("pulse_10", 64'(m_tdata[39]), 64'(head_report.p10));
                if (m_tdata[40] !== head_report.p50)
                    report_mismatch("pulse_50", 64'(m_tdata[40]), 64'(head_report.p50));
                if (m_tdata[41] !== head_report.bad)
                    report_mismatch("bad_id", 64'(m_tdata[41]), 64'(head_report.bad));
                if (m_tdata[47:42] !== '0)
                    report_mismatch("padding", 64'(m_tdata[47:42]), 64'(0));
            end
            results_seen++;
        end
    end

    // Watchdog: a stuck handshake ends the run as a failure
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Long receiver hold-off early on, so the output register fills and the
    // block has to stall its command input while the sender keeps offering
    initial begin
        wait (commands_sent >= 150);
        hold_off = 1'b1;
        repeat (HOLD_OFF_CYCLES) @(posedge aclk);
        hold_off = 1'b0;
    end

    initial begin
        int unsigned useful;
        int unsigned pick;
        logic [CMD_W-1:0]    cmd;
        logic [ID_W-1:0]     id;
        logic [PERIOD_W-1:0] period;

        // Directed part: ticks ignore id and period, so give the first one all ones
        queue_command(CMD_TICK, 8'hFF, 32'hFFFF_FFFF);
        queue_command(CMD_ONCE, 8'd0, 32'd1);
        queue_command(CMD_AUTO, 8'd7, 32'd2);
        queue_command(CMD_ONCE, 8'd3, 32'd0);            // period zero: armed, never fires
        queue_command(CMD_AUTO, 8'd4, 32'hFFFF_FFFF);    // longest period
        queue_command(CMD_STOP, 8'd5, 32'd0);            // stop a timer that never ran
        queue_command(CMD_ONCE, 8'd8, 32'd5);            // first id beyond the bank
        queue_command(CMD_AUTO, 8'hFF, 32'd1);
        queue_command(CMD_STOP, 8'hC8, 32'hAAAA_5555);
        queue_command(CMD_TICK, 8'd0, 32'd0);
        queue_command(CMD_TICK, 8'd0, 32'd0);
        queue_command(CMD_AUTO, 8'd1, 32'd1);            // reload of one fires every tick
        queue_command(CMD_TICK, 8'd0, 32'd0);
        queue_command(CMD_TICK, 8'd0, 32'd0);
        queue_command(CMD_STOP, 8'd1, 32'd0);            // stopped auto timer keeps counting
        queue_command(CMD_TICK, 8'd0, 32'd0);
        queue_command(CMD_ONCE, 8'd2, 32'd3);
        queue_command(CMD_STOP, 8'd2, 32'd0);
        queue_command(CMD_TICK, 8'd0, 32'd0);
        queue_command(CMD_TICK, 8'd0, 32'd0);
        queue_command(CMD_TICK, 8'd0, 32'd0);
        // Every timer expiring on the same tick
        for (int k = 0; k < N_TIMERS; k++)
            queue_command(CMD_ONCE, k[ID_W-1:0], 32'd1);
        queue_command(CMD_TICK, 8'd0, 32'd0);

        // Random part: mostly ticks and short-period starts so timers fire
        // often; a share of noise with wild ids and full-range periods.
        useful = 0;
        while (useful < RANDOM_COMMANDS) begin
            pick   = $urandom_range(99);
            id     = ID_W'($urandom_range(N_TIMERS - 1));
            period = $urandom_range(1, 12);
            if (pick < 50) begin
                cmd    = CMD_TICK;
                id     = ID_W'($urandom);
                period = $urandom;
            end else if (pick < 75) begin
                cmd = ($urandom_range(1) == 0) ? CMD_ONCE : CMD_AUTO;
                if ($urandom_range(19) == 0)
                    period = '0;
                else if ($urandom_range(9) == 0)
                    period = $urandom;
            end else if (pick < 85) begin
                cmd = CMD_STOP;
            end else if (pick < 92) begin
                cmd    = CMD_W'($urandom_range(CMD_ONCE, CMD_STOP));
                id     = ID_W'($urandom_range(N_TIMERS, 255));
                period = $urandom;
            end else begin
                cmd    = CMD_W'($urandom_range(CMD_ONCE, CMD_STOP));
                id     = ID_W'($urandom);
                period = $urandom;
            end
            queue_command(cmd, id, period);
            useful++;
        end
        total_commands = commands_to_send.size();

        // Hold reset low, then release it at a falling edge
        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;

        // Wait for every command to go through, then for every result
        while (commands_to_send.size() != 0 || s_tvalid)
            @(posedge aclk);
        while (timer_reports_due.size() != 0)
            @(posedge aclk);
        // Allow a full tick sweep for any stray extra result to show up
        repeat (2 * N_TIMERS + 4) @(posedge aclk);

        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
